// ===== rtl/trfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the tablet record framer.
// Used by trfd_decode and tablet_record_framer_decoder; depends on nothing.
package trfd_pkg;

    localparam int MAX_RECORD_BYTES = 17;
    localparam int BUF_IDX_W        = $clog2(MAX_RECORD_BYTES);
    localparam int FILL_W           = $clog2(MAX_RECORD_BYTES + 1);

    // Tablet type register codes.
    localparam logic [3:0] TT_OFF        = 4'd0;
    localparam logic [3:0] TT_LOW5_A     = 4'd1;
    localparam logic [3:0] TT_LOW5_B     = 4'd2;
    localparam logic [3:0] TT_EIGHT      = 4'd3;
    localparam logic [3:0] TT_TRACKER    = 4'd4;
    localparam logic [3:0] TT_NEW5_PROX  = 4'd5;
    localparam logic [3:0] TT_SIX_PROX   = 4'd6;
    localparam logic [3:0] TT_NEW5       = 4'd7;
    localparam logic [3:0] TT_SIX        = 4'd8;
    localparam logic [3:0] TT_RESET      = TT_LOW5_A;

    typedef logic [2:0] t_kind;

    // Record formats.
    localparam t_kind KIND_NONE    = 3'd0;
    localparam t_kind KIND_OLD5    = 3'd1;
    localparam t_kind KIND_EIGHT   = 3'd2;
    localparam t_kind KIND_TRACKER = 3'd3;
    localparam t_kind KIND_NEW5    = 3'd4;
    localparam t_kind KIND_SIX     = 3'd5;

    localparam logic [7:0]  SYNC_STD_MASK    = 8'h80;
    localparam logic [7:0]  SYNC_NEW5_MASK   = 8'h40;
    localparam logic [15:0] INPROX           = 16'h8000;
    localparam logic [15:0] PROX_BIT         = 16'h0010;
    localparam logic [6:0]  KEY_SPACE        = 7'h20;
    localparam logic [5:0]  OLD5_BUTTON_MIN  = 6'd30;
    localparam logic [13:0] PROX_MIN_X       = 14'd256;
    localparam logic [4:0]  PRESS_BUTTON_MIN = 5'd16;

    typedef logic [MAX_RECORD_BYTES-1:0][6:0] t_rec;

    typedef struct packed {
        logic [20:0] x;
        logic [20:0] y;
        logic [15:0] z;
        logic [15:0] azimuth;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] status;
        logic [4:0]  pressure;
        logic [13:0] tilt;
        logic [6:0]  key;
        logic [15:0] count;
    } t_holds;

    function automatic t_kind kind_of(input logic [3:0] tt);
        t_kind k;
        case (tt) inside
            TT_LOW5_A, TT_LOW5_B: k = KIND_OLD5;
            TT_EIGHT:             k = KIND_EIGHT;
            TT_TRACKER:           k = KIND_TRACKER;
            TT_NEW5_PROX, TT_NEW5: k = KIND_NEW5;
            TT_SIX_PROX, TT_SIX:  k = KIND_SIX;
            default:              k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [FILL_W-1:0] size_of(input t_kind k);
        logic [FILL_W-1:0] s;
        case (k)
            KIND_OLD5:    s = FILL_W'(5);
            KIND_EIGHT:   s = FILL_W'(8);
            KIND_TRACKER: s = FILL_W'(17);
            KIND_NEW5:    s = FILL_W'(5);
            KIND_SIX:     s = FILL_W'(6);
            default:      s = '0;
        endcase
        return s;
    endfunction

    function automatic logic prox_of(input logic [3:0] tt);
        return (tt == TT_NEW5_PROX) || (tt == TT_SIX_PROX);
    endfunction

endpackage

// ===== rtl/trfd_decode.sv =====
`timescale 1ns / 1ps
// Record decoder: turns one complete record into the next held values.
// Depends on trfd_pkg for the record and hold types and format codes.
module trfd_decode (
    input  trfd_pkg::t_rec   i_rec,
    input  trfd_pkg::t_kind  i_kind,
    input  logic             i_prox,
    input  trfd_pkg::t_holds i_hold,
    output trfd_pkg::t_holds o_hold
);

    logic [15:0] st;
    logic [13:0] x14;
    logic [5:0]  b6;
    logic [3:0]  idx;

    always_comb begin
        o_hold = i_hold;
        st     = '0;
        x14    = '0;
        b6     = '0;
        idx    = '0;
        case (i_kind)
            trfd_pkg::KIND_OLD5: begin
                b6 = i_rec[0][5:0];
                st = i_rec[0][6] ? trfd_pkg::INPROX : 16'd0;
                // Button codes above 036 select one status bit, two codes per bit; code 037 also selects bit 0.
                if (b6 > trfd_pkg::OLD5_BUTTON_MIN) begin
                    idx = b6[5] ? b6[4:1] : 4'd0;
                    st  = st | (16'd1 << idx);
                end
                x14 = {i_rec[1], i_rec[2]};
                if (x14 < trfd_pkg::PROX_MIN_X) begin
                    st = st & ~trfd_pkg::INPROX;
                end
                o_hold.x      = 21'(x14);
                o_hold.y      = 21'({i_rec[3], i_rec[4]});
                o_hold.status = st;
                o_hold.count  = i_hold.count + 16'd1;
            end
            trfd_pkg::KIND_EIGHT: begin
                o_hold.pressure = i_rec[0][6:2];
                st    = trfd_pkg::INPROX;
                st[0] = (i_rec[0][6:2] > trfd_pkg::PRESS_BUTTON_MIN);
                o_hold.status = st;
                o_hold.x      = 21'({i_rec[0][1:0], i_rec[1], i_rec[2]});
                o_hold.y      = 21'({i_rec[3][1:0], i_rec[4], i_rec[5]});
                o_hold.tilt   = {i_rec[7], i_rec[6]};
                o_hold.count  = i_hold.count + 16'd1;
            end
            trfd_pkg::KIND_TRACKER: begin
                o_hold.x       = 21'({i_rec[9][1:0], i_rec[3], i_rec[4]});
                o_hold.y       = 21'({i_rec[9][3:2], i_rec[5], i_rec[6]});
                o_hold.z       = {i_rec[9][5:4], i_rec[7], i_rec[8]};
                o_hold.azimuth = {i_rec[16][1:0], i_rec[10], i_rec[11]};
                o_hold.pitch   = {i_rec[16][3:2], i_rec[12], i_rec[13]};
                o_hold.roll    = {i_rec[16][5:4], i_rec[14], i_rec[15]};
                o_hold.status  = {2'b00, i_rec[0], i_rec[1]};
                // A space in the key byte means no key, so the last key is kept.
                if (i_rec[2] != trfd_pkg::KEY_SPACE) begin
                    o_hold.key = i_rec[2];
                end
            end
            trfd_pkg::KIND_NEW5: begin
                st = trfd_pkg::INPROX | 16'(i_rec[0][5:2]);
                if (i_prox && st[4]) begin
                    st = st & ~(trfd_pkg::PROX_BIT | trfd_pkg::INPROX);
                end
                o_hold.status = st;
                // The two coordinate bytes overlap by one bit in this format.
                o_hold.x     = 21'(13'(i_rec[1]) | (13'(i_rec[2]) << 6));
                o_hold.y     = 21'(13'(i_rec[3]) | (13'(i_rec[4]) << 6));
                o_hold.count = i_hold.count + 16'd1;
            end
            trfd_pkg::KIND_SIX: begin
                o_hold.x = 21'({i_rec[0][1:0], i_rec[1], i_rec[2]});
                o_hold.y = {i_rec[3], i_rec[4], i_rec[5]};
                st = trfd_pkg::INPROX | 16'(i_rec[0][6:2]);
                if (i_prox && st[4]) begin
                    st = st & ~(trfd_pkg::PROX_BIT | trfd_pkg::INPROX);
                end
                o_hold.status = st;
                o_hold.count  = i_hold.count + 16'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/tablet_record_framer_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the tablet record framer: input register, framing, decode, result.
// Depends on trfd_pkg and trfd_decode.
// A byte accepted into the input register is framed there; a completing byte shows
// its result on o_valid once the result register loads it. Throughput is one byte per
// cycle; a completing byte waits in the input register only while a stalled result is held.
// Reset (synchronous, active low) clears the fill count, all held values and the
// valid flags, and sets the tablet type to 1; the record buffer is not cleared.
module tablet_record_framer_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_x_position,
    output logic [20:0] o_y_position,
    output logic [15:0] o_z_position,
    output logic [15:0] o_azimuth,
    output logic [15:0] o_pitch_angle,
    output logic [15:0] o_roll_angle,
    output logic [15:0] o_status_bits,
    output logic [4:0]  o_pressure,
    output logic [6:0]  o_x_tilt,
    output logic [6:0]  o_y_tilt,
    output logic [6:0]  o_held_key,
    output logic [15:0] o_sample_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]                       r_type;
    logic                             r_in_valid;
    logic [7:0]                       r_in_byte;
    logic [trfd_pkg::FILL_W-1:0]      r_fill;
    trfd_pkg::t_rec                   r_buf;
    trfd_pkg::t_holds                 r_hold;
    logic                             r_out_valid;

    trfd_pkg::t_kind                  kind;
    logic [trfd_pkg::FILL_W-1:0]      size;
    logic [7:0]                       sync_mask;
    logic                             restart;
    logic [trfd_pkg::FILL_W-1:0]      wr_idx;
    logic [trfd_pkg::FILL_W-1:0]      n_fill;
    logic                             complete;
    logic                             out_free;
    logic                             proc;
    logic                             cfg_wr;
    trfd_pkg::t_rec                   rec;
    trfd_pkg::t_holds                 n_hold;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(r_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= trfd_pkg::TT_RESET;
        end else if (cfg_wr) begin
            r_type <= pwdata[3:0];
        end
    end

    // Framing of the byte held in the input register.
    assign kind      = trfd_pkg::kind_of(r_type);
    assign size      = trfd_pkg::size_of(kind);
    assign sync_mask = (kind == trfd_pkg::KIND_NEW5) ? trfd_pkg::SYNC_NEW5_MASK
                                                     : trfd_pkg::SYNC_STD_MASK;
    assign restart   = ((r_in_byte & sync_mask) != 8'd0) || (r_fill >= size);
    assign wr_idx    = restart ? '0 : r_fill;
    assign n_fill    = wr_idx + trfd_pkg::FILL_W'(1);
    assign complete  = (kind != trfd_pkg::KIND_NONE) && (n_fill == size);

    // The decoder sees the buffer with the incoming byte already in its slot.
    always_comb begin
        for (int i = 0; i < trfd_pkg::MAX_RECORD_BYTES; i++) begin
            rec[i] = (wr_idx == trfd_pkg::FILL_W'(i)) ? r_in_byte[6:0] : r_buf[i];
        end
    end

    trfd_decode u_decode (
        .i_rec  (rec),
        .i_kind (kind),
        .i_prox (trfd_pkg::prox_of(r_type)),
        .i_hold (r_hold),
        .o_hold (n_hold)
    );

    // Only a byte that completes a record has to wait for the result register.
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && (!complete || out_free);
    assign o_stall  = r_in_valid && !proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (kind != trfd_pkg::KIND_NONE)
                && (wr_idx < trfd_pkg::FILL_W'(trfd_pkg::MAX_RECORD_BYTES))) begin
            r_buf[wr_idx[trfd_pkg::BUF_IDX_W-1:0]] <= r_in_byte[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (proc && (kind != trfd_pkg::KIND_NONE)) begin
                r_fill <= n_fill;
            end
            if (proc && complete) begin
                r_hold      <= n_hold;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The held values are the result payload; they change only when a new one is loaded.
    assign o_valid        = r_out_valid;
    assign o_x_position   = r_hold.x;
    assign o_y_position   = r_hold.y;
    assign o_z_position   = r_hold.z;
    assign o_azimuth      = r_hold.azimuth;
    assign o_pitch_angle  = r_hold.pitch;
    assign o_roll_angle   = r_hold.roll;
    assign o_status_bits  = r_hold.status;
    assign o_pressure     = r_hold.pressure;
    assign o_x_tilt       = r_hold.tilt[6:0];
    assign o_y_tilt       = r_hold.tilt[13:7];
    assign o_held_key     = r_hold.key;
    assign o_sample_count = r_hold.count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= trfd_pkg::FILL_W'(trfd_pkg::MAX_RECORD_BYTES))
        else $error("fill count beyond record buffer depth");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && complete))
        else $error("input stalled without a blocked result");

    a_count_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && complete && (kind != trfd_pkg::KIND_TRACKER))
        |=> (r_hold.count == $past(r_hold.count) + 16'd1))
        else $error("sample count not bumped on decoded record");

    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (kind == trfd_pkg::KIND_NONE)) |=> ($stable(r_fill) && !$rose(o_valid)))
        else $error("disabled type changed framing state");

endmodule
